// ===== sv/tdpt_pkg.sv =====
package tdpt_pkg;

	localparam int PC_W = 3;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_CLASSIFY,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_TEST,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_SPECIAL,
		C_DIV_BUSY,
		C_TEST_DONE,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	typedef struct packed {
		op_t op;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic special;
		logic div_last;
		logic test_done;
		logic out_free;
	} stat_t;

	localparam pc_t PC_WAIT    = 3'd0;
	localparam pc_t PC_DIV     = 3'd2;
	localparam pc_t PC_DIVSTEP = 3'd3;
	localparam pc_t PC_EMIT    = 3'd6;

	// condition true: jump to target, else fall through
	function automatic uword_t ucode_rom(pc_t pc);
		uword_t w;
		unique case (pc)
			3'd0: w = '{OP_LOAD,     C_NO_IN,     PC_WAIT};
			3'd1: w = '{OP_CLASSIFY, C_SPECIAL,   PC_EMIT};
			3'd2: w = '{OP_DIV_INIT, C_NEVER,     PC_WAIT};
			3'd3: w = '{OP_DIV_STEP, C_DIV_BUSY,  PC_DIVSTEP};
			3'd4: w = '{OP_TEST,     C_TEST_DONE, PC_EMIT};
			3'd5: w = '{OP_NOP,      C_ALWAYS,    PC_DIV};
			3'd6: w = '{OP_EMIT,     C_OUT_FREE,  PC_WAIT};
			3'd7: w = '{OP_NOP,      C_ALWAYS,    PC_EMIT};
			default: w = '{OP_NOP, C_ALWAYS, PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/tdpt_in_if.sv =====
interface tdpt_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/tdpt_out_if.sv =====
interface tdpt_out_if;
	logic valid;
	logic ready;
	logic is_prime;

	modport source (output valid, output is_prime, input ready);
	modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== sv/tdpt_seq.sv =====
module tdpt_seq
	import tdpt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	pc_t    pc_q;
	pc_t    pc_next;
	uword_t uw;
	logic   take;

	always_comb begin
		uw = ucode_rom(pc_q);
		unique case (uw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_IN:     take = !stat.in_valid;
			C_SPECIAL:   take = stat.special;
			C_DIV_BUSY:  take = !stat.div_last;
			C_TEST_DONE: take = stat.test_done;
			C_OUT_FREE:  take = stat.out_free;
			default:     take = 1'b0;
		endcase
		pc_next = take ? uw.target : pc_q + pc_t'(1);
		ctrl.op = uw.op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// ===== sv/tdpt_dp.sv =====
module tdpt_dp
	import tdpt_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_t                 ctrl,
	output stat_t                 stat,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] in_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  out_is_prime
);

	localparam int W     = DATA_WIDTH;
	localparam int CNT_W = $clog2(DATA_WIDTH);

	logic [W-1:0]     v_q;
	logic [W-1:0]     d_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             result_q;
	logic             out_valid_q;
	logic             is_prime_q;

	logic [W:0]       part;
	logic             ge;
	logic             d_gt_q;
	logic             out_free;

	assign part     = {rem_q, quo_q[W-1]};
	assign ge       = part >= {1'b0, d_q};
	assign d_gt_q   = d_q > quo_q;
	assign out_free = !out_valid_q || out_ready;

	assign in_ready     = ctrl.op == OP_LOAD;
	assign out_valid    = out_valid_q;
	assign out_is_prime = is_prime_q;

	always_comb begin
		stat.in_valid  = in_valid;
		stat.special   = v_q[W-1] || (v_q <= W'(1)) || !v_q[0];
		stat.div_last  = cnt_q == CNT_W'(W - 1);
		stat.test_done = d_gt_q || (rem_q == '0);
		stat.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				if (in_valid) v_q <= in_value;
			end
			OP_CLASSIFY: begin
				result_q <= v_q == W'(2);
				d_q      <= W'(3);
			end
			OP_DIV_INIT: begin
				rem_q <= '0;
				quo_q <= v_q;
				cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? W'(part - {1'b0, d_q}) : part[W-1:0];
				quo_q <= {quo_q[W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			OP_TEST: begin
				result_q <= d_gt_q;
				d_q      <= d_q + W'(2);
			end
			OP_EMIT: begin
				if (out_free) is_prime_q <= result_q;
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/trial_division_prime_test.sv =====
// channel  dir  fields                  handshake
// req      in   value[DATA_WIDTH-1:0]   valid/ready
// rsp      out  is_prime                valid/ready
//
// One item at a time. Negative, 0, 1, 2 and even values skip the divider.
// Odd values: one pass of the one-bit-per-cycle restoring divider per odd trial
// divisor; worst case near 23170 divisors at 32 bits.
// arst_n clears the microcode program counter and the result valid flag.
// A stalled result waits in the output register; the next item is taken meanwhile.
module trial_division_prime_test
	import tdpt_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	tdpt_in_if.sink   req,
	tdpt_out_if.source rsp
);

	ctrl_t ctrl;
	stat_t stat;

	tdpt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	tdpt_dp #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.in_valid     (req.valid),
		.in_ready     (req.ready),
		.in_value     (req.value),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_is_prime (rsp.is_prime)
	);

endmodule

// ===== sv/tdpt_chk.sv =====
module tdpt_chk #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [DATA_WIDTH-1:0] value,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  is_prime
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_prime))
		else $error("result dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("second item taken while one is in work");

	a_negative: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && value[DATA_WIDTH-1] && !out_valid |-> ##3 out_valid && !is_prime)
		else $error("negative item not answered as not prime");

	a_two: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && value == DATA_WIDTH'(2) && !out_valid |-> ##3 out_valid && is_prime)
		else $error("two not answered as prime");

endmodule

bind trial_division_prime_test tdpt_chk #(
	.DATA_WIDTH(DATA_WIDTH)
) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.value     (req.value),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.is_prime  (rsp.is_prime)
);

// ===== tb/sv/tb.sv =====
module tb;

	localparam int DATA_WIDTH  = 32;
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int DRAIN_WAIT  = 40;
	localparam int RANDOM_ITEMS = 68;

	typedef logic signed [DATA_WIDTH-1:0] value_t;

	class prime_scoreboard;
		typedef struct {
			value_t value;
			bit     prime;
		} verdict_t;

		verdict_t verdict_q[$];
		int       errors;

		function bit prime_by_trial(value_t raw);
			longint unsigned v;
			longint unsigned d;
			v = longint'(unsigned'(raw));
			if (raw[DATA_WIDTH-1])
				return 1'b0;
			if (v <= 1)
				return 1'b0;
			if (v == 2)
				return 1'b1;
			if (v[0] == 1'b0)
				return 1'b0;
			for (d = 3; d <= v / d; d += 2) begin
				if (v % d == 0)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_value(value_t v);
			verdict_t e;
			e.value = v;
			e.prime = prime_by_trial(v);
			verdict_q.push_back(e);
		endfunction

		function void check_result(logic got);
			verdict_t e;
			if (verdict_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got is_prime=%0b", $time, got);
				return;
			end
			e = verdict_q.pop_front();
			if (got !== e.prime) begin
				errors++;
				$display("%0t: is_prime of %0d: expected %0b, got %0b",
					$time, e.value, e.prime, got);
			end
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tdpt_in_if #(.DATA_WIDTH(DATA_WIDTH)) req();
	tdpt_out_if rsp();

	trial_division_prime_test #(
		.DATA_WIDTH(DATA_WIDTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	prime_scoreboard sb = new();

	bit steady;
	int hold_cycles;
	int cycle_count;

	int directed_vals[] = '{
		32'h8000_0000, -1, 0, 1, 2, 3, 4, 5, 7, 9, 15, 25, 49, 121, 169, 961,
		97, 1009, 65521, 1000003, 2147483646, 2147483645, 32'hAAAA_AAAA,
		2147483647
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			sb.note_value(req.value);
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result(rsp.is_prime);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// cheap values dominate; slow odd values stay small
	function automatic value_t random_value();
		int unsigned v;
		int unsigned k;
		int unsigned lim;
		int unsigned a;
		int unsigned b;
		case ($urandom_range(0, 9))
			0: begin
				v = $urandom;
				if (!v[31])
					v[0] = 1'b0;
			end
			1: v = $urandom | 32'h8000_0000;
			2, 3: v = $urandom_range(0, 300);
			4, 5: v = $urandom_range(0, 16383) * 2 + 1;
			6: begin
				k = $urandom_range(1, 31) * 2 + 1;
				lim = 32'h7FFF_FFFF / k;
				v = k * ($urandom_range(1, lim - 1) | 1);
			end
			7: begin
				a = $urandom_range(1, 100) * 2 + 1;
				v = a * a;
			end
			8: begin
				a = $urandom_range(1, 250) * 2 + 1;
				b = $urandom_range(1, 250) * 2 + 1;
				v = a * b;
			end
			default: v = {1'($urandom_range(0, 1)), 30'($urandom), 1'b0};
		endcase
		return value_t'(v);
	endfunction

	task automatic send_value(input value_t v);
		if (!steady)
			repeat (pick_gap()) @(negedge clk);
		req.valid = 1'b1;
		req.value = v;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		req.valid = 1'b0;
		req.value = value_t'($urandom);
	endtask

	task automatic wait_results();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// receiver: random runs and gaps, plus long hold-offs on request
	initial begin
		int rx_run;
		int rx_gap;
		rx_run = 0;
		rx_gap = 0;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp.ready = 1'b0;
				hold_cycles--;
			end else if (rx_run > 0) begin
				rsp.ready = 1'b1;
				rx_run--;
			end else if (rx_gap > 0) begin
				rsp.ready = 1'b0;
				rx_gap--;
			end else begin
				rsp.ready = 1'b1;
				rx_run = $urandom_range(0, 7);
				rx_gap = steady ? 0 : pick_gap();
			end
		end
	end

	initial begin
		steady = 1'b0;
		hold_cycles = 0;
		cycle_count = 0;
		req.valid = 1'b0;
		req.value = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_vals[i])
			send_value(value_t'(directed_vals[i]));
		wait_results();

		// back-pressure: block fills up and stalls its input
		hold_cycles = 400;
		steady = 1'b1;
		repeat (8)
			send_value(value_t'({1'($urandom_range(0, 1)), 30'($urandom), 1'b0}));
		steady = 1'b0;
		wait_results();

		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(0, 24) == 0)
				steady = !steady;
			send_value(random_value());
		end
		steady = 1'b0;

		wait_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
